[rtl/lrupr_pkg.sv]
// Shared types and constants for the LRU page-frame table.
// Used by the configuration block, the frame cells and the top level.
package lrupr_pkg;

  localparam int NumFrames = 8;
  localparam int PageW     = 16;
  localparam int SlotW     = (NumFrames > 1) ? $clog2(NumFrames) : 1;
  localparam int CntW      = $clog2(NumFrames + 1);
  localparam int CfgW      = 4;

  typedef logic [PageW-1:0] page_t;
  typedef logic [SlotW-1:0] slot_t;
  typedef logic [SlotW-1:0] rank_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [CfgW-1:0]  cfg_t;

  // Register index bit (byte address bit 2)
  localparam logic RegFramesInUse = 1'b0;
  localparam cfg_t FramesReset    = cfg_t'(8);

  // Lookup data handed from cell to cell
  typedef struct packed {
    logic  found;
    slot_t slot;
    rank_t rank;
    logic  lru;
    slot_t vslot;
    page_t vpage;
  } link_t;

  // Update command broadcast to every cell
  typedef struct packed {
    logic  en;
    logic  wr_page;
    logic  age_all;
    slot_t slot;
    rank_t limit;
    page_t page;
  } upd_t;

endpackage

[rtl/lrupr_cfg.sv]
// APB configuration register for the LRU page-frame table.
// Holds the frame count, clamps it and flags a table clear on write. Uses lrupr_pkg.
module lrupr_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lrupr_pkg::cnt_t   eff_frames_o,
  output logic              clear_o
);

  lrupr_pkg::cfg_t frames_q, frames_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == lrupr_pkg::RegFramesInUse);

  assign frames_d = wr_en ? lrupr_pkg::cfg_t'(pwdata[lrupr_pkg::CfgW-1:0]) : frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lrupr_pkg::FramesReset;
    end else begin
      frames_q <= frames_d;
    end
  end

  assign clear_o = wr_en;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == lrupr_pkg::RegFramesInUse) begin
      prdata = 32'(frames_q);
    end
  end

  // Zero acts as one frame, anything above the table size as the full table
  always_comb begin
    priority if (frames_q == '0) begin
      eff_frames_o = lrupr_pkg::cnt_t'(1);
    end else if (32'(frames_q) > 32'(lrupr_pkg::NumFrames)) begin
      eff_frames_o = lrupr_pkg::cnt_t'(lrupr_pkg::NumFrames);
    end else begin
      eff_frames_o = lrupr_pkg::cnt_t'(frames_q);
    end
  end

endmodule

[rtl/lrupr_cell.sv]
// One frame cell: holds a resident page and its recency rank.
// Compares, passes the lookup link on to its neighbor and applies updates. Uses lrupr_pkg.
module lrupr_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrupr_pkg::slot_t   cell_idx_i,
  input  lrupr_pkg::cnt_t    occ_i,
  input  lrupr_pkg::rank_t   lru_rank_i,
  input  lrupr_pkg::upd_t    upd_i,
  input  lrupr_pkg::link_t   link_i,
  output lrupr_pkg::link_t   link_o
);

  lrupr_pkg::page_t page_q, page_d;
  lrupr_pkg::rank_t rank_q, rank_d;
  logic             occupied;
  logic             match;
  logic             is_lru;
  logic             sel;

  assign occupied = lrupr_pkg::cnt_t'(cell_idx_i) < occ_i;
  assign match    = occupied && (page_q == upd_i.page);
  assign is_lru   = occupied && (rank_q == lru_rank_i);
  assign sel      = (cell_idx_i == upd_i.slot);

  always_comb begin
    link_o = link_i;
    if (match && !link_i.found) begin
      link_o.found = 1'b1;
      link_o.slot  = cell_idx_i;
      link_o.rank  = rank_q;
    end
    if (is_lru) begin
      link_o.lru   = 1'b1;
      link_o.vslot = cell_idx_i;
      link_o.vpage = page_q;
    end
  end

  always_comb begin
    rank_d = rank_q;
    page_d = page_q;
    if (upd_i.en) begin
      if (sel) begin
        rank_d = '0;
        if (upd_i.wr_page) begin
          page_d = upd_i.page;
        end
      end else if (occupied && (upd_i.age_all || (rank_q < upd_i.limit))) begin
        rank_d = lrupr_pkg::rank_t'(rank_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else begin
      rank_q <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

[rtl/lru_page_replacement.sv]
// LRU page-frame table top level: request register, row of frame cells, result register.
// Depends on lrupr_pkg, lrupr_cfg and lrupr_cell.
//
//   channel   | direction | handshake                    | payload
//   ----------+-----------+------------------------------+-------------------------------
//   request   | in        | start, busy                  | page_number_i
//   result    | out       | result_valid_o (strobe)      | hit_o, frame_slot_o,
//             |           |                              | evicted_valid_o, evicted_page_o,
//             |           |                              | fault_total_o
//   config    | in/out    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// In a transaction the accept edge registers the page, the next edge runs the
// lookup through the cell row and applies the update; the result strobe follows that edge.
// busy is high for one cycle after each accept. Reset empties the table and clears the
// fault count; writing frames_in_use empties the table and keeps the count.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lru_page_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] page_number_i,
  output logic        result_valid_o,
  output logic        hit_o,
  output logic [2:0]  frame_slot_o,
  output logic        evicted_valid_o,
  output logic [15:0] evicted_page_o,
  output logic [31:0] fault_total_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lrupr_pkg::cnt_t  eff_frames;
  logic             clear;

  logic             busy_q, busy_d;
  lrupr_pkg::page_t req_q, req_d;
  lrupr_pkg::cnt_t  occ_q, occ_d;
  logic [31:0]      fault_q, fault_d;

  logic             res_valid_q;
  logic             res_hit_q;
  lrupr_pkg::slot_t res_slot_q;
  logic             res_ev_q;
  lrupr_pkg::page_t res_evpage_q;

  lrupr_pkg::link_t link [lrupr_pkg::NumFrames+1];
  lrupr_pkg::link_t last;
  lrupr_pkg::upd_t  upd;
  lrupr_pkg::rank_t lru_rank;
  logic             hit;
  logic             insert;
  logic             evict;
  lrupr_pkg::slot_t slot;

  lrupr_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .eff_frames_o (eff_frames),
    .clear_o      (clear)
  );

  assign link[0]  = '0;
  assign lru_rank = lrupr_pkg::rank_t'(occ_q - 1'b1);

  for (genvar g = 0; g < lrupr_pkg::NumFrames; g++) begin : g_cell
    lrupr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (lrupr_pkg::slot_t'(g)),
      .occ_i      (occ_q),
      .lru_rank_i (lru_rank),
      .upd_i      (upd),
      .link_i     (link[g]),
      .link_o     (link[g+1])
    );
  end

  assign last   = link[lrupr_pkg::NumFrames];
  assign hit    = last.found;
  assign insert = !hit && (occ_q < eff_frames);
  assign evict  = !hit && !insert;

  always_comb begin
    priority if (hit) begin
      slot = last.slot;
    end else if (insert) begin
      slot = lrupr_pkg::slot_t'(occ_q);
    end else begin
      slot = last.vslot;
    end
  end

  always_comb begin
    upd.en      = busy_q;
    upd.wr_page = !hit;
    upd.age_all = !hit;
    upd.slot    = slot;
    upd.limit   = last.rank;
    upd.page    = req_q;
  end

  always_comb begin
    busy_d  = busy_q;
    req_d   = req_q;
    occ_d   = occ_q;
    fault_d = fault_q;
    if (start && !busy_q) begin
      busy_d = 1'b1;
      req_d  = lrupr_pkg::page_t'(page_number_i);
    end
    if (busy_q) begin
      busy_d = 1'b0;
      if (insert) begin
        occ_d = lrupr_pkg::cnt_t'(occ_q + 1'b1);
      end
      // hold the count at its maximum
      if (!hit && (fault_q != '1)) begin
        fault_d = fault_q + 32'd1;
      end
    end
    if (clear) begin
      occ_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      occ_q       <= '0;
      fault_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      occ_q       <= occ_d;
      fault_q     <= fault_d;
      res_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (busy_q) begin
      res_hit_q    <= hit;
      res_slot_q   <= slot;
      res_ev_q     <= evict;
      res_evpage_q <= evict ? last.vpage : '0;
    end
  end

  assign busy            = busy_q;
  assign result_valid_o  = res_valid_q;
  assign hit_o           = res_hit_q;
  assign frame_slot_o    = 3'(res_slot_q);
  assign evicted_valid_o = res_ev_q;
  assign evicted_page_o  = 16'(res_evpage_q);
  assign fault_total_o   = fault_q;

endmodule

[rtl/lrupr_checker.sv]
// Port-level checks for the LRU page-frame table.
// Bound to lru_page_replacement; sees its ports only.
module lrupr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic        hit_o,
  input logic        evicted_valid_o,
  input logic [15:0] evicted_page_o,
  input logic [31:0] fault_total_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o && !busy)
    else $error("result strobe missing after busy cycle");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (hit_o || !evicted_valid_o) |-> evicted_page_o == 16'd0 &&
      !(hit_o && evicted_valid_o))
    else $error("eviction reported without a replaced page");

  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !hit_o |->
      fault_total_o != $past(fault_total_o) || fault_total_o == 32'hFFFF_FFFF)
    else $error("fault count did not advance on a miss");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);
